### hdl/lfuttl_pkg.sv
// Shared types and constants for the LFU/TTL set-associative cache.
package lfuttl_pkg;

  localparam int TAG_W  = 23;
  localparam int DATA_W = 32;
  localparam int FREQ_W = 16;
  localparam int TTL_W  = 16;

  typedef logic [TAG_W-1:0]         tag_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [FREQ_W-1:0]        freq_t;
  typedef logic [TTL_W-1:0]         ttl_t;

  localparam freq_t FREQ_MAX       = '1;
  localparam freq_t FREQ_FILL      = freq_t'(1);
  localparam ttl_t  LIFETIME_RESET = ttl_t'(300);

  typedef struct packed {
    logic go;
    logic fill;
  } access_t;

  function automatic freq_t freq_bump(input freq_t f);
    freq_bump = (f == FREQ_MAX) ? f : f + freq_t'(1);
  endfunction

endpackage

### hdl/lfuttl_store.sv
// Per-way tag, data and frequency memories with registered row read and write bypass.
module lfuttl_store #(
  parameter int NSETS = 16,
  parameter int WAYS  = 4,
  parameter int SET_W = 4,
  parameter int WAY_W = 2
) (
  input  logic                  clk,
  input  logic [SET_W-1:0]      rd_set,
  input  lfuttl_pkg::access_t   wr_acc,
  input  logic [SET_W-1:0]      wr_set,
  input  logic [WAY_W-1:0]      wr_way,
  input  lfuttl_pkg::tag_t      wr_tag,
  input  lfuttl_pkg::data_t     wr_data,
  input  lfuttl_pkg::freq_t     wr_freq,
  output lfuttl_pkg::tag_t      rd_tag  [WAYS],
  output lfuttl_pkg::data_t     rd_data [WAYS],
  output lfuttl_pkg::freq_t     rd_freq [WAYS]
);
  import lfuttl_pkg::*;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    tag_t  tag_mem  [NSETS];
    data_t data_mem [NSETS];
    freq_t freq_mem [NSETS];
    tag_t  tag_q_r;
    data_t data_q_r;
    freq_t freq_q_r;
    tag_t  tag_byp_r;
    data_t data_byp_r;
    freq_t freq_byp_r;
    logic  line_byp_r;
    logic  freq_byp_en_r;
    logic  freq_we;
    logic  line_we;

    assign freq_we = wr_acc.go && (wr_way == WAY_W'(w));
    assign line_we = freq_we && wr_acc.fill;

    always_ff @(posedge clk) begin
      if (freq_we) begin
        freq_mem[wr_set] <= wr_freq;
      end
      if (line_we) begin
        tag_mem[wr_set]  <= wr_tag;
        data_mem[wr_set] <= wr_data;
      end
      tag_q_r       <= tag_mem[rd_set];
      data_q_r      <= data_mem[rd_set];
      freq_q_r      <= freq_mem[rd_set];
      freq_byp_en_r <= freq_we && (wr_set == rd_set);
      line_byp_r    <= line_we && (wr_set == rd_set);
      tag_byp_r     <= wr_tag;
      data_byp_r    <= wr_data;
      freq_byp_r    <= wr_freq;
    end

    assign rd_tag[w]  = line_byp_r    ? tag_byp_r  : tag_q_r;
    assign rd_data[w] = line_byp_r    ? data_byp_r : data_q_r;
    assign rd_freq[w] = freq_byp_en_r ? freq_byp_r : freq_q_r;
  end

endmodule

### hdl/lfuttl_life.sv
// Valid bits and per-line lifetime counters, aged once per access.
module lfuttl_life #(
  parameter int NSETS = 16,
  parameter int WAYS  = 4,
  parameter int SET_W = 4,
  parameter int WAY_W = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lfuttl_pkg::access_t acc,
  input  logic [SET_W-1:0]    set,
  input  logic [WAY_W-1:0]    way,
  input  lfuttl_pkg::ttl_t    lifetime,
  output logic [WAYS-1:0]     valid_row
);
  import lfuttl_pkg::*;

  logic valid_r   [NSETS][WAYS];
  logic valid_nxt [NSETS][WAYS];
  ttl_t ttl_r     [NSETS][WAYS];
  ttl_t ttl_nxt   [NSETS][WAYS];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      valid_row[w] = valid_r[set][w];
    end
  end

  always_comb begin
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        valid_nxt[s][w] = valid_r[s][w];
        ttl_nxt[s][w]   = ttl_r[s][w];
        if (acc.go && acc.fill && (set == SET_W'(s)) && (way == WAY_W'(w))) begin
          valid_nxt[s][w] = 1'b1;
          ttl_nxt[s][w]   = lifetime;
        end
        if (acc.go && valid_nxt[s][w] && (ttl_nxt[s][w] != '0)) begin
          ttl_nxt[s][w] = ttl_nxt[s][w] - ttl_t'(1);
          if (ttl_nxt[s][w] == '0) begin
            valid_nxt[s][w] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        if (!rst_n) begin
          valid_r[s][w] <= 1'b0;
          ttl_r[s][w]   <= '0;
        end else begin
          valid_r[s][w] <= valid_nxt[s][w];
          ttl_r[s][w]   <= ttl_nxt[s][w];
        end
      end
    end
  end

endmodule

### hdl/lfuttl_lookup.sv
// Tag match across the ways of one set and least-frequently-used victim choice.
module lfuttl_lookup #(
  parameter int WAYS  = 4,
  parameter int WAY_W = 2
) (
  input  logic [WAYS-1:0]   valid_row,
  input  lfuttl_pkg::tag_t  tags  [WAYS],
  input  lfuttl_pkg::freq_t freqs [WAYS],
  input  lfuttl_pkg::tag_t  req_tag,
  input  logic              req_fits,
  output logic              hit,
  output logic [WAY_W-1:0]  hit_way,
  output logic [WAY_W-1:0]  victim_way
);
  import lfuttl_pkg::*;

  logic  found_inv;
  freq_t best_freq;

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && valid_row[w] && req_fits && (tags[w] == req_tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    found_inv  = 1'b0;
    victim_way = '0;
    best_freq  = freqs[0];
    for (int w = 0; w < WAYS; w++) begin
      if (!found_inv) begin
        if (!valid_row[w]) begin
          found_inv  = 1'b1;
          victim_way = WAY_W'(w);
        end else if (w == 0 || freqs[w] < best_freq) begin
          best_freq  = freqs[w];
          victim_way = WAY_W'(w);
        end
      end
    end
  end

endmodule

### hdl/lfu_ttl_set_assoc_cache.sv
// Top level of the set-associative read cache with LFU replacement and line lifetime.
//
// Use: present a read request on in_request_id with its backing value on in_fill_data
// and raise start; the request transfers at the rising edge where start is high and
// busy is low. busy stays low, so a request may transfer on every cycle.
// Each request gives exactly one result: out_valid is high for one cycle with
// out_read_data (cached value on a hit, in_fill_data on a miss), out_was_hit and
// out_way_used. The strobe follows the transfer through the s1_go_r and out_valid_r
// registers, and results keep request order.
// Throughput is one request per cycle: the set row is read from the way memories
// at the transfer edge, then tag match, victim choice, row write-back and aging of
// all line lifetimes happen in the next cycle; back-to-back requests to one set are
// served by a one-deep write bypass on the row read.
// cfg_we with cfg_wdata sets the lifetime of newly filled lines; write it only idle.
// Reset (rst_n low, synchronous) invalidates every line and sets the lifetime to 300.
// The receiver cannot stall; a result must be taken in its strobe cycle.
module lfu_ttl_set_assoc_cache #(
  parameter int LINES       = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [30:0]              in_request_id,
  input  lfuttl_pkg::data_t        in_fill_data,
  output logic                     out_valid,
  output lfuttl_pkg::data_t        out_read_data,
  output logic                     out_was_hit,
  output logic [1:0]               out_way_used,
  input  logic                     cfg_we,
  input  lfuttl_pkg::ttl_t         cfg_wdata
);
  import lfuttl_pkg::*;

  localparam int NSETS = (LINES / WAYS > 0) ? LINES / WAYS : 1;
  localparam int BB_LG = $clog2(BLOCK_BYTES);
  localparam int LN_LG = $clog2(LINES);
  localparam int WY_LG = $clog2(WAYS);
  localparam int SET_W = (NSETS > 1) ? $clog2(NSETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  ttl_t              lifetime_r;
  logic [30:0]       blk_addr;
  logic [30:0]       tag_full;
  logic [30:0]       set_full;
  logic [SET_W-1:0]  in_set;
  logic              accept;

  logic              s1_go_r;
  tag_t              s1_tag_r;
  logic              s1_fits_r;
  logic [SET_W-1:0]  s1_set_r;
  data_t             s1_fill_r;

  tag_t              row_tag  [WAYS];
  data_t             row_data [WAYS];
  freq_t             row_freq [WAYS];
  logic [WAYS-1:0]   valid_row;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  victim_way;
  logic [WAY_W-1:0]  way_sel;
  access_t           acc;
  freq_t             freq_wr;
  data_t             data_sel;

  logic              out_valid_r;
  data_t             out_read_data_r;
  logic              out_was_hit_r;
  logic [1:0]        out_way_used_r;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign blk_addr = in_request_id >> BB_LG;
  assign tag_full = blk_addr >> LN_LG;
  assign set_full = (blk_addr >> WY_LG) & 31'(NSETS - 1);
  assign in_set   = set_full[SET_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= LIFETIME_RESET;
      s1_go_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        lifetime_r <= cfg_wdata;
      end
      s1_go_r <= accept;
    end
    s1_tag_r  <= tag_full[TAG_W-1:0];
    s1_fits_r <= (tag_full >> TAG_W) == 31'd0;
    s1_set_r  <= in_set;
    s1_fill_r <= in_fill_data;
  end

  lfuttl_store #(
    .NSETS (NSETS),
    .WAYS  (WAYS),
    .SET_W (SET_W),
    .WAY_W (WAY_W)
  ) u_store (
    .clk     (clk),
    .rd_set  (in_set),
    .wr_acc  (acc),
    .wr_set  (s1_set_r),
    .wr_way  (way_sel),
    .wr_tag  (s1_tag_r),
    .wr_data (s1_fill_r),
    .wr_freq (freq_wr),
    .rd_tag  (row_tag),
    .rd_data (row_data),
    .rd_freq (row_freq)
  );

  lfuttl_life #(
    .NSETS (NSETS),
    .WAYS  (WAYS),
    .SET_W (SET_W),
    .WAY_W (WAY_W)
  ) u_life (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .set       (s1_set_r),
    .way       (way_sel),
    .lifetime  (lifetime_r),
    .valid_row (valid_row)
  );

  lfuttl_lookup #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_lookup (
    .valid_row  (valid_row),
    .tags       (row_tag),
    .freqs      (row_freq),
    .req_tag    (s1_tag_r),
    .req_fits   (s1_fits_r),
    .hit        (hit),
    .hit_way    (hit_way),
    .victim_way (victim_way)
  );

  assign way_sel  = hit ? hit_way : victim_way;
  assign acc.go   = s1_go_r;
  assign acc.fill = !hit;
  assign freq_wr  = hit ? freq_bump(row_freq[hit_way]) : FREQ_FILL;
  assign data_sel = hit ? row_data[hit_way] : s1_fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_go_r;
    end
    out_read_data_r <= data_sel;
    out_was_hit_r   <= hit;
    out_way_used_r  <= 2'(way_sel);
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_was_hit   = out_was_hit_r;
  assign out_way_used  = out_way_used_r;

endmodule
